// ===== hdl/cgp_pkg.sv =====
package cgp_pkg;

    localparam logic [1:0] ACT_GATE = 2'd0;
    localparam logic [1:0] ACT_TAP  = 2'd1;
    localparam logic [1:0] ACT_EVAL = 2'd2;

    localparam logic [2:0] REG_MASK    = 3'd0;
    localparam logic [2:0] REG_INPUTS  = 3'd1;
    localparam logic [2:0] REG_OUTPUTS = 3'd2;
    localparam logic [2:0] REG_ROWS    = 3'd3;
    localparam logic [2:0] REG_COLUMNS = 3'd4;

    localparam int FN_AND  = 0;
    localparam int FN_OR   = 1;
    localparam int FN_XOR  = 2;
    localparam int FN_NOTA = 3;
    localparam int FN_NAND = 4;
    localparam int FN_XNOR = 5;
    localparam int FN_COUNT = 7;

    localparam int PADDR_W = 5;

    typedef struct packed {
        logic [6:0] func_enable_mask;
        logic [3:0] input_count;
        logic [3:0] output_count;
        logic [3:0] row_count;
        logic [4:0] column_count;
    } cfg_t;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] src_a;
        logic [7:0] src_b;
    } gate_entry_t;

    // code selects the code-th enabled function; past the last one gives 0
    function automatic logic gate_eval(logic [6:0] mask, logic [2:0] code,
                                       logic a, logic b);
        logic [2:0] n;
        logic       r;
        logic       hit;
        n   = '0;
        r   = 1'b0;
        hit = 1'b0;
        for (int k = 0; k < FN_COUNT; k++)
        begin
            if (mask[k])
            begin
                if (!hit && n == code)
                begin
                    hit = 1'b1;
                    case (k)
                        FN_AND:  r = a & b;
                        FN_OR:   r = a | b;
                        FN_XOR:  r = a ^ b;
                        FN_NOTA: r = ~a;
                        FN_NAND: r = ~(a & b);
                        FN_XNOR: r = ~(a ^ b);
                        default: r = ~(a | b);
                    endcase
                end
                n = n + 3'd1;
            end
        end
        return r;
    endfunction

endpackage

// ===== hdl/cgp_cfg_regs.sv =====
module cgp_cfg_regs
    import cgp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.func_enable_mask <= 7'd127;
            cfg_reg.input_count      <= 4'd8;
            cfg_reg.output_count     <= 4'd8;
            cfg_reg.row_count        <= 4'd8;
            cfg_reg.column_count     <= 5'd16;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_MASK:    cfg_reg.func_enable_mask <= pwdata[6:0];
                REG_INPUTS:  cfg_reg.input_count      <= pwdata[3:0];
                REG_OUTPUTS: cfg_reg.output_count     <= pwdata[3:0];
                REG_ROWS:    cfg_reg.row_count        <= pwdata[3:0];
                REG_COLUMNS: cfg_reg.column_count     <= pwdata[4:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_MASK:    prdata = {25'd0, cfg_reg.func_enable_mask};
            REG_INPUTS:  prdata = {28'd0, cfg_reg.input_count};
            REG_OUTPUTS: prdata = {28'd0, cfg_reg.output_count};
            REG_ROWS:    prdata = {28'd0, cfg_reg.row_count};
            REG_COLUMNS: prdata = {27'd0, cfg_reg.column_count};
            default:     prdata = '0;
        endcase
    end

endmodule

// ===== hdl/cgp_gate_mem.sv =====
module cgp_gate_mem
    import cgp_pkg::*;
#(
    parameter int DEPTH = 128,
    parameter int AW    = 7
)
(
    input  logic        clk,
    input  logic        we,
    input  logic [AW-1:0] waddr,
    input  gate_entry_t wdata,
    input  logic [AW-1:0] raddr,
    output gate_entry_t rdata
);

    gate_entry_t mem [DEPTH];
    gate_entry_t rdata_reg;

    assign rdata = rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

endmodule

// ===== hdl/cgp_cell_mem.sv =====
module cgp_cell_mem
#(
    parameter int DEPTH = 128,
    parameter int AW    = 7
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic          wdata,
    input  logic [AW-1:0] raddr_a,
    input  logic [AW-1:0] raddr_b,
    output logic          rdata_a,
    output logic          rdata_b
);

    logic mem [DEPTH];
    logic rdata_a_reg;
    logic rdata_b_reg;

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

endmodule

// ===== hdl/cgp_gate_grid_evaluator.sv =====
// Channel  | Dir | Handshake                  | Payload
// item     | in  | item_valid / item_stall    | action slot gate_function source_a
//          |     |                            | source_b input_vector
// result   | out | result_valid / result_stall| output_vector
// config   | in  | APB psel/penable/pwrite    | paddr pwdata prdata pready
//
// Gate and tap writes never stall the input. An evaluate item raises result_valid
// once rows*columns gates and output_count taps (saturated counts) have drained,
// and the input reopens in the same cycle: the sequencer issues one gate or tap per
// cycle through the gate memory read, the cell memory read and the write-back.
// No clearing pass after reset: a cell reads as computed only below the
// current gate index, so stale cell memory contents are never seen.
// The next item is taken while a result waits; a finished evaluation holds
// until the result register is free.
module cgp_gate_grid_evaluator
    import cgp_pkg::*;
#(
    parameter int MAX_ROWS    = 8,
    parameter int MAX_COLUMNS = 16,
    parameter int IO_WIDTH    = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic [1:0]         action,
    input  logic [6:0]         slot,
    input  logic [2:0]         gate_function,
    input  logic [7:0]         source_a,
    input  logic [7:0]         source_b,
    input  logic [7:0]         input_vector,
    output logic               result_valid,
    input  logic               result_stall,
    output logic [7:0]         output_vector,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int CELL_DEPTH = MAX_ROWS * MAX_COLUMNS;
    localparam int CA_W  = (CELL_DEPTH > 1) ? $clog2(CELL_DEPTH) : 1;
    localparam int CNT_W = $clog2(CELL_DEPTH + 1);
    localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;
    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int CW    = $clog2(MAX_COLUMNS + 1);
    localparam int TAP_W = (IO_WIDTH > 1) ? $clog2(IO_WIDTH) : 1;
    localparam int TPW   = $clog2(IO_WIDTH + 1);

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;

    typedef struct packed {
        logic            is_node;
        logic            in_bit;
        logic [CA_W-1:0] addr;
    } sel_dec_t;

    cfg_t cfg;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] gate_ptr_reg, gate_ptr_next;
    logic [TPW-1:0]   tap_ptr_reg, tap_ptr_next;
    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic result_valid_reg, result_valid_next;

    logic [CNT_W-1:0] total_reg;
    logic [7:0]       vec_reg;
    logic [IO_WIDTH-1:0] res_acc_reg;
    logic [7:0]       result_reg;
    logic [7:0]       tap_store_reg [IO_WIDTH];

    logic            s1_tap_reg;
    logic [CA_W-1:0] s1_gidx_reg;
    logic [TAP_W-1:0] s1_tidx_reg;

    logic            s2_tap_reg;
    logic [CA_W-1:0] s2_gidx_reg;
    logic [TAP_W-1:0] s2_tidx_reg;
    logic [2:0]      s2_func_reg;
    logic            s2_a_cell_reg, s2_a_bit_reg, s2_a_fwd_reg, s2_a_fwdv_reg;
    logic            s2_b_cell_reg, s2_b_bit_reg, s2_b_fwd_reg, s2_b_fwdv_reg;

    logic item_accept;
    logic gate_we;
    logic tap_we;
    logic eval_start;
    logic issue_gate;
    logic issue_tap;
    logic drained;
    logic out_free;

    logic [RW-1:0]    rows_eff;
    logic [CW-1:0]    cols_eff;
    logic [3:0]       ins_eff;
    logic [3:0]       outs_eff;
    logic [CNT_W-1:0] total_next;

    gate_entry_t gate_wdata;
    gate_entry_t gate_rdata;
    logic [7:0]       s1_src_a;
    logic [CNT_W-1:0] s1_limit;
    sel_dec_t         dec_a;
    sel_dec_t         dec_b;

    logic cell_rd_a, cell_rd_b;
    logic op_a, op_b;
    logic cell_we;
    logic cell_wval;

    function automatic sel_dec_t decode_sel(logic [7:0] sel, logic [3:0] ins,
                                            logic [CNT_W-1:0] limit,
                                            logic [7:0] vec);
        sel_dec_t         d;
        logic [CMP_W-1:0] idx;
        d   = '0;
        idx = '0;
        if (sel < 8'(ins))
        begin
            d.in_bit = vec[sel[2:0]];
        end
        else
        begin
            // cell index = column*rows + row, so the column bound is idx < rows*cols
            idx = CMP_W'(sel) - CMP_W'(ins);
            if (idx < CMP_W'(limit))
            begin
                d.is_node = 1'b1;
                d.addr    = idx[CA_W-1:0];
            end
        end
        return d;
    endfunction

    cgp_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign gate_wdata.func  = gate_function;
    assign gate_wdata.src_a = source_a;
    assign gate_wdata.src_b = source_b;

    cgp_gate_mem #(
        .DEPTH (CELL_DEPTH),
        .AW    (CA_W)
    ) u_gate_mem (
        .clk   (clk),
        .we    (gate_we),
        .waddr (CA_W'(slot)),
        .wdata (gate_wdata),
        .raddr (gate_ptr_reg[CA_W-1:0]),
        .rdata (gate_rdata)
    );

    cgp_cell_mem #(
        .DEPTH (CELL_DEPTH),
        .AW    (CA_W)
    ) u_cell_mem (
        .clk     (clk),
        .we      (cell_we),
        .waddr   (s2_gidx_reg),
        .wdata   (cell_wval),
        .raddr_a (dec_a.addr),
        .raddr_b (dec_b.addr),
        .rdata_a (cell_rd_a),
        .rdata_b (cell_rd_b)
    );

    // effective counts
    always_comb
    begin
        if (cfg.row_count == 4'd0)
            rows_eff = RW'(1);
        else if (32'(cfg.row_count) > MAX_ROWS)
            rows_eff = RW'(MAX_ROWS);
        else
            rows_eff = RW'(cfg.row_count);

        if (32'(cfg.column_count) > MAX_COLUMNS)
            cols_eff = CW'(MAX_COLUMNS);
        else
            cols_eff = CW'(cfg.column_count);

        if (32'(cfg.input_count) > IO_WIDTH)
            ins_eff = 4'(IO_WIDTH);
        else
            ins_eff = cfg.input_count;

        if (32'(cfg.output_count) > IO_WIDTH)
            outs_eff = 4'(IO_WIDTH);
        else
            outs_eff = cfg.output_count;

        total_next = CNT_W'(32'(rows_eff) * 32'(cols_eff));
    end

    assign item_stall  = (state_reg != ST_IDLE);
    assign item_accept = item_valid && !item_stall;
    assign gate_we     = item_accept && action == ACT_GATE && 32'(slot) < CELL_DEPTH;
    assign tap_we      = item_accept && action == ACT_TAP && 32'(slot) < IO_WIDTH;
    assign eval_start  = item_accept && action == ACT_EVAL;

    assign issue_gate = (state_reg == ST_RUN) && gate_ptr_reg < total_reg;
    assign issue_tap  = (state_reg == ST_RUN) && !issue_gate
                        && 32'(tap_ptr_reg) < 32'(outs_eff);
    assign drained    = !issue_gate && !issue_tap && !s1_valid_reg && !s2_valid_reg;
    assign out_free   = !result_valid_reg || !result_stall;

    // stage 1: gate entry is here, decode sources and read cells
    assign s1_src_a = s1_tap_reg ? tap_store_reg[s1_tidx_reg] : gate_rdata.src_a;
    assign s1_limit = s1_tap_reg ? total_reg : CNT_W'(s1_gidx_reg);
    assign dec_a    = decode_sel(s1_src_a, ins_eff, s1_limit, vec_reg);
    assign dec_b    = decode_sel(gate_rdata.src_b, ins_eff, s1_limit, vec_reg);

    // stage 2: evaluate and write back
    assign op_a = s2_a_cell_reg ? (s2_a_fwd_reg ? s2_a_fwdv_reg : cell_rd_a) : s2_a_bit_reg;
    assign op_b = s2_b_cell_reg ? (s2_b_fwd_reg ? s2_b_fwdv_reg : cell_rd_b) : s2_b_bit_reg;
    assign cell_wval = gate_eval(cfg.func_enable_mask, s2_func_reg, op_a, op_b);
    assign cell_we   = s2_valid_reg && !s2_tap_reg;

    always_comb
    begin
        state_next        = state_reg;
        gate_ptr_next     = gate_ptr_reg;
        tap_ptr_next      = tap_ptr_reg;
        s1_valid_next     = issue_gate || issue_tap;
        s2_valid_next     = s1_valid_reg;
        result_valid_next = result_valid_reg && result_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (eval_start)
                begin
                    state_next    = ST_RUN;
                    gate_ptr_next = '0;
                    tap_ptr_next  = '0;
                end
            end
            ST_RUN:
            begin
                if (issue_gate)
                    gate_ptr_next = gate_ptr_reg + CNT_W'(1);
                else if (issue_tap)
                    tap_ptr_next = tap_ptr_reg + TPW'(1);
                else if (drained)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            gate_ptr_reg     <= '0;
            tap_ptr_reg      <= '0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            gate_ptr_reg     <= gate_ptr_next;
            tap_ptr_reg      <= tap_ptr_next;
            s1_valid_reg     <= s1_valid_next;
            s2_valid_reg     <= s2_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tap_we)
            tap_store_reg[TAP_W'(slot)] <= source_a;

        if (eval_start)
        begin
            total_reg   <= total_next;
            vec_reg     <= input_vector;
            res_acc_reg <= '0;
        end
        else if (s2_valid_reg && s2_tap_reg)
        begin
            res_acc_reg[s2_tidx_reg] <= op_a;
        end

        s1_tap_reg  <= issue_tap;
        s1_gidx_reg <= gate_ptr_reg[CA_W-1:0];
        s1_tidx_reg <= tap_ptr_reg[TAP_W-1:0];

        s2_tap_reg    <= s1_tap_reg;
        s2_gidx_reg   <= s1_gidx_reg;
        s2_tidx_reg   <= s1_tidx_reg;
        s2_func_reg   <= gate_rdata.func;
        s2_a_cell_reg <= dec_a.is_node;
        s2_a_bit_reg  <= dec_a.in_bit;
        s2_b_cell_reg <= dec_b.is_node;
        s2_b_bit_reg  <= dec_b.in_bit;
        // the cell written this cycle is not yet in the memory read data
        s2_a_fwd_reg  <= cell_we && dec_a.addr == s2_gidx_reg;
        s2_b_fwd_reg  <= cell_we && dec_b.addr == s2_gidx_reg;
        s2_a_fwdv_reg <= cell_wval;
        s2_b_fwdv_reg <= cell_wval;

        if (state_reg == ST_DONE && out_free)
            result_reg <= 8'(res_acc_reg);
    end

    assign result_valid  = result_valid_reg;
    assign output_vector = result_reg;

endmodule

// ===== verif/tb_top.sv =====
module tb_top
    import cgp_pkg::*;
();

    localparam int MAX_ROWS      = 8;
    localparam int MAX_COLUMNS   = 16;
    localparam int IO_WIDTH      = 8;
    localparam int GRID_CELLS    = MAX_ROWS * MAX_COLUMNS;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int CONFIG_SETTLE = 16;
    localparam int FINAL_SETTLE  = 160;
    localparam int RANDOM_PHASES = 10;
    localparam int HOLD_CYCLES   = 300;
    localparam int DIR_ROWS      = 26;

    localparam logic [1:0] ACT_NONE     = 2'd3;
    localparam logic [2:0] FN_CODE_PAST = 3'd7;

    typedef struct packed {
        logic [1:0] action;
        logic [6:0] slot;
        logic [2:0] fn;
        logic [7:0] src_a;
        logic [7:0] src_b;
        logic [7:0] vec;
    } grid_item_t;

    typedef struct packed {
        grid_item_t item;
        logic       known;
        logic [7:0] want;
    } directed_row_t;

    // Grid of 1 row x 8 columns, 2 inputs. Gates 0..6 apply each function to
    // in0/in1, gate 7 inverts itself (reads 0, not yet computed), tap t reads
    // cell t.
    localparam directed_row_t DIR_TABLE [DIR_ROWS] = '{
        '{'{ACT_GATE, 7'd0, 3'(FN_AND),  8'd0, 8'd1,   8'h00}, 1'b0, 8'h00},
        '{'{ACT_GATE, 7'd1, 3'(FN_OR),   8'd0, 8'd1,   8'h00}, 1'b0, 8'h00},
        '{'{ACT_GATE, 7'd2, 3'(FN_XOR),  8'd0, 8'd1,   8'h00}, 1'b0, 8'h00},
        '{'{ACT_GATE, 7'd3, 3'(FN_NOTA), 8'd0, 8'd1,   8'h00}, 1'b0, 8'h00},
        '{'{ACT_GATE, 7'd4, 3'(FN_NAND), 8'd0, 8'd1,   8'h00}, 1'b0, 8'h00},
        '{'{ACT_GATE, 7'd5, 3'(FN_XNOR), 8'd0, 8'd1,   8'h00}, 1'b0, 8'h00},
        '{'{ACT_GATE, 7'd6, 3'd6,        8'd0, 8'd1,   8'h00}, 1'b0, 8'h00},
        '{'{ACT_GATE, 7'd7, 3'(FN_NOTA), 8'd9, 8'd255, 8'h00}, 1'b0, 8'h00},
        '{'{ACT_TAP,  7'd0, 3'd0,        8'd2, 8'd0,   8'h00}, 1'b0, 8'h00},
        '{'{ACT_TAP,  7'd1, 3'd0,        8'd3, 8'd0,   8'h00}, 1'b0, 8'h00},
        '{'{ACT_TAP,  7'd2, 3'd0,        8'd4, 8'd0,   8'h00}, 1'b0, 8'h00},
        '{'{ACT_TAP,  7'd3, 3'd0,        8'd5, 8'd0,   8'h00}, 1'b0, 8'h00},
        '{'{ACT_TAP,  7'd4, 3'd0,        8'd6, 8'd0,   8'h00}, 1'b0, 8'h00},
        '{'{ACT_TAP,  7'd5, 3'd0,        8'd7, 8'd0,   8'h00}, 1'b0, 8'h00},
        '{'{ACT_TAP,  7'd6, 3'd0,        8'd8, 8'd0,   8'h00}, 1'b0, 8'h00},
        '{'{ACT_TAP,  7'd7, 3'd0,        8'd9, 8'd0,   8'h00}, 1'b0, 8'h00},
        '{'{ACT_EVAL, 7'd0, 3'd0,        8'd0, 8'd0,   8'h00}, 1'b1, 8'hF8},
        '{'{ACT_EVAL, 7'd0, 3'd0,        8'd0, 8'd0,   8'h01}, 1'b1, 8'h96},
        '{'{ACT_EVAL, 7'd0, 3'd0,        8'd0, 8'd0,   8'h02}, 1'b1, 8'h9E},
        '{'{ACT_EVAL, 7'd0, 3'd0,        8'd0, 8'd0,   8'h03}, 1'b1, 8'hA3},
        // upper input bits are unused with two inputs
        '{'{ACT_EVAL, 7'd0, 3'd0,        8'd0, 8'd0,   8'hFF}, 1'b1, 8'hA3},
        // tap slot past the last tap is dropped, unused action too
        '{'{ACT_TAP,  7'd8, 3'd0,        8'd0, 8'd0,   8'h00}, 1'b0, 8'h00},
        '{'{ACT_NONE, 7'd0, 3'd0,        8'd0, 8'd0,   8'hFF}, 1'b0, 8'h00},
        '{'{ACT_GATE, 7'd6, FN_CODE_PAST, 8'd0, 8'd1,  8'h00}, 1'b0, 8'h00},
        '{'{ACT_TAP,  7'd5, 3'd0,        8'd255, 8'd0, 8'h00}, 1'b0, 8'h00},
        '{'{ACT_EVAL, 7'd0, 3'd0,        8'd0, 8'd0,   8'h00}, 1'b1, 8'h98}
    };

    logic               clk = 1'b0;
    logic               rst_n;
    logic               item_valid;
    logic               item_stall;
    logic [1:0]         action;
    logic [6:0]         slot;
    logic [2:0]         gate_function;
    logic [7:0]         source_a;
    logic [7:0]         source_b;
    logic [7:0]         input_vector;
    logic               result_valid;
    logic               result_stall;
    logic [7:0]         output_vector;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    // predictor state
    logic [6:0] cfg_mask = 7'h7F;
    logic [3:0] cfg_ins  = 4'd8;
    logic [3:0] cfg_outs = 4'd8;
    logic [3:0] cfg_rows = 4'd8;
    logic [4:0] cfg_cols = 5'd16;
    logic [2:0] g_func  [GRID_CELLS];
    logic [7:0] g_src_a [GRID_CELLS];
    logic [7:0] g_src_b [GRID_CELLS];
    logic [7:0] tap_sel [IO_WIDTH];
    logic       cell_val [GRID_CELLS];
    bit         gate_loaded [GRID_CELLS];
    bit         tap_loaded [IO_WIDTH];

    logic [7:0] expected_outputs [$];
    logic [7:0] result_want;
    int         fail_count = 0;
    int         cycle_count = 0;
    bit         idle_on = 1'b0;
    int         hold_request = 0;

    cgp_gate_grid_evaluator dut (
        .clk, .rst_n, .item_valid, .item_stall, .action, .slot, .gate_function,
        .source_a, .source_b, .input_vector, .result_valid, .result_stall,
        .output_vector, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int clip(int v, int hi);
        return (v > hi) ? hi : v;
    endfunction

    function automatic int grid_rows();
        return (cfg_rows == 0) ? 1 : clip(int'(cfg_rows), MAX_ROWS);
    endfunction

    function automatic logic gate_result(logic [2:0] code, logic a, logic b);
        int order [FN_COUNT];
        int n;
        n = 0;
        for (int k = 0; k < FN_COUNT; k++)
        begin
            if (cfg_mask[k])
            begin
                order[n] = k;
                n++;
            end
        end
        if (int'(code) >= n)
            return 1'b0;
        case (order[code])
            FN_AND:  return a & b;
            FN_OR:   return a | b;
            FN_XOR:  return a ^ b;
            FN_NOTA: return ~a;
            FN_NAND: return ~(a & b);
            FN_XNOR: return ~(a ^ b);
            default: return ~(a | b);
        endcase
    endfunction

    // cell index maps straight onto grid position: col*rows + row == index
    function automatic logic select_bit(logic [7:0] sel, logic [7:0] vec, int ins,
                                        int rows, int cols);
        int idx;
        if (int'(sel) < ins)
            return vec[sel[2:0]];
        idx = int'(sel) - ins;
        if (idx / rows >= cols)
            return 1'b0;
        return cell_val[idx];
    endfunction

    function automatic logic [7:0] predict_outputs(logic [7:0] vec);
        int         rows;
        int         cols;
        int         ins;
        logic       a;
        logic       b;
        logic [7:0] res;
        rows = grid_rows();
        cols = clip(int'(cfg_cols), MAX_COLUMNS);
        ins  = clip(int'(cfg_ins), IO_WIDTH);
        res  = '0;
        for (int i = 0; i < GRID_CELLS; i++)
            cell_val[i] = 1'b0;
        for (int i = 0; i < rows * cols; i++)
        begin
            a = select_bit(g_src_a[i], vec, ins, rows, cols);
            b = select_bit(g_src_b[i], vec, ins, rows, cols);
            cell_val[i] = gate_result(g_func[i], a, b);
        end
        for (int t = 0; t < clip(int'(cfg_outs), IO_WIDTH); t++)
            res[t] = select_bit(tap_sel[t], vec, ins, rows, cols);
        return res;
    endfunction

    // mostly an input bit or a cell below limit, sometimes anything
    function automatic logic [7:0] source_for(int limit);
        int ins;
        int r;
        ins = clip(int'(cfg_ins), IO_WIDTH);
        r   = $urandom_range(0, 99);
        if (r < 35 && ins > 0)
            return 8'($urandom_range(0, ins - 1));
        if (r < 88 && limit > 0)
            return 8'(ins + $urandom_range(0, limit - 1));
        return 8'($urandom);
    endfunction

    task automatic send_item(input grid_item_t it, input bit known, input logic [7:0] want);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        item_valid    <= 1'b1;
        action        <= it.action;
        slot          <= it.slot;
        gate_function <= it.fn;
        source_a      <= it.src_a;
        source_b      <= it.src_b;
        input_vector  <= it.vec;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        case (it.action)
            ACT_GATE:
            begin
                g_func[it.slot]      = it.fn;
                g_src_a[it.slot]     = it.src_a;
                g_src_b[it.slot]     = it.src_b;
                gate_loaded[it.slot] = 1'b1;
            end
            ACT_TAP:
            begin
                if (it.slot < IO_WIDTH)
                begin
                    tap_sel[it.slot[2:0]]    = it.src_a;
                    tap_loaded[it.slot[2:0]] = 1'b1;
                end
            end
            ACT_EVAL:
                expected_outputs.insert(expected_outputs.size(),
                                        known ? want : predict_outputs(it.vec));
            default: ;
        endcase
    endtask

    task automatic drain(input int settle);
        item_valid <= 1'b0;
        @(posedge clk);
        while (expected_outputs.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_config(input logic [6:0] mask, input logic [3:0] ins,
                                input logic [3:0] outs, input logic [3:0] rows,
                                input logic [4:0] cols);
        logic [31:0] vals [5];
        vals[REG_MASK]    = 32'(mask);
        vals[REG_INPUTS]  = 32'(ins);
        vals[REG_OUTPUTS] = 32'(outs);
        vals[REG_ROWS]    = 32'(rows);
        vals[REG_COLUMNS] = 32'(cols);
        psel   <= 1'b1;
        pwrite <= 1'b1;
        for (int r = 0; r < 5; r++)
        begin
            paddr   <= PADDR_W'(r * 4);
            pwdata  <= vals[r];
            penable <= 1'b0;
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            while (!pready)
                @(posedge clk);
        end
        psel     <= 1'b0;
        penable  <= 1'b0;
        cfg_mask = mask;
        cfg_ins  = ins;
        cfg_outs = outs;
        cfg_rows = rows;
        cfg_cols = cols;
    endtask

    // receiver side: short random stalls, or one long hold on request
    initial
    begin
        int span;
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                span         = hold_request;
                hold_request = 0;
                result_stall <= 1'b1;
                repeat (span) @(posedge clk);
                result_stall <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_outputs.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected item: output_vector=%h with none pending",
                             output_vector);
            end
            else
            begin
                result_want = expected_outputs.pop_front();
                if (output_vector !== result_want)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("output_vector mismatch: expected %h, got %h",
                                 result_want, output_vector);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        grid_item_t it;
        int         phase_len;
        int         sent;
        int         kind;
        int         cells;
        int         outs;
        int         miss_gate;
        int         miss_tap;

        rst_n         <= 1'b0;
        item_valid    <= 1'b0;
        action        <= ACT_GATE;
        slot          <= '0;
        gate_function <= '0;
        source_a      <= '0;
        source_b      <= '0;
        input_vector  <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        write_config(7'h7F, 4'd2, 4'd8, 4'd1, 5'd8);
        idle_on = 1'b1;
        for (int i = 0; i < DIR_ROWS; i++)
            send_item(DIR_TABLE[i].item, DIR_TABLE[i].known, DIR_TABLE[i].want);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            drain(CONFIG_SETTLE);
            case (p)
                0: write_config(7'h7F, 4'd8, 4'd8, 4'd8, 5'd16);
                1: write_config(7'($urandom), 4'd3, 4'd4, 4'd2, 5'd3);
                2: write_config(7'h00, 4'd1, 4'd1, 4'd1, 5'd1);
                3: write_config(7'($urandom), 4'd15, 4'd15, 4'd15, 5'd31);
                4: write_config(7'($urandom), 4'd0, 4'd0, 4'd0, 5'd0);
                default: write_config(7'($urandom), 4'($urandom_range(1, 8)),
                                      4'($urandom_range(1, 8)), 4'($urandom_range(1, 4)),
                                      5'($urandom_range(1, 6)));
            endcase
            idle_on   = (p != 2 && p != RANDOM_PHASES - 1);
            phase_len = (p == 0) ? 300 : (p == 2) ? 40 : (p == 4) ? 30 : 80;
            // fill the block while the receiver holds off
            if (p == 1)
                hold_request = HOLD_CYCLES;
            sent = 0;
            while (sent < phase_len)
            begin
                cells    = grid_rows() * clip(int'(cfg_cols), MAX_COLUMNS);
                outs     = clip(int'(cfg_outs), IO_WIDTH);
                it.slot  = 7'($urandom);
                it.fn    = 3'($urandom_range(0, 6));
                it.src_a = 8'($urandom);
                it.src_b = 8'($urandom);
                it.vec   = 8'($urandom);
                kind     = $urandom_range(0, 99);
                if (kind < 50)
                begin
                    // evaluate only once every gate and tap in use is loaded
                    miss_gate = -1;
                    miss_tap  = -1;
                    for (int g = cells - 1; g >= 0; g--)
                        if (!gate_loaded[g])
                            miss_gate = g;
                    for (int t = outs - 1; t >= 0; t--)
                        if (!tap_loaded[t])
                            miss_tap = t;
                    it.action = ACT_EVAL;
                    if (miss_gate >= 0)
                    begin
                        it.action = ACT_GATE;
                        it.slot   = 7'(miss_gate);
                        it.src_a  = source_for(miss_gate);
                        it.src_b  = source_for(miss_gate);
                    end
                    else if (miss_tap >= 0)
                    begin
                        it.action = ACT_TAP;
                        it.slot   = 7'(miss_tap);
                        it.src_a  = source_for(cells);
                    end
                end
                else if (kind < 78)
                begin
                    it.action = ACT_GATE;
                    if (cells > 0 && $urandom_range(0, 9) != 0)
                        it.slot = 7'($urandom_range(0, cells - 1));
                    if ($urandom_range(0, 15) == 0)
                        it.fn = FN_CODE_PAST;
                    it.src_a = source_for(int'(it.slot));
                    it.src_b = source_for(int'(it.slot));
                end
                else if (kind < 95)
                begin
                    it.action = ACT_TAP;
                    it.slot   = ($urandom_range(0, 9) != 0) ? 7'($urandom_range(0, 7))
                                                            : 7'($urandom_range(8, 127));
                    it.src_a  = source_for(cells);
                end
                else
                    it.action = ACT_NONE;
                send_item(it, 1'b0, 8'h00);
                if (it.action != ACT_NONE)
                    sent++;
            end
        end

        drain(FINAL_SETTLE);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
